FILE: src/tdm_pkg.sv
// package for the trinomial discriminant block
// types, widths, sequencer states and job codes; no dependencies
package tdm_pkg;
  localparam int MOD_BITS = 32;
  localparam int DEG_BITS = 16;

  typedef struct packed {
    logic [DEG_BITS-1:0] degree;
    logic [DEG_BITS-1:0] mid_exponent;
    logic [MOD_BITS-1:0] coeff_a;
    logic [MOD_BITS-1:0] coeff_b;
  } in_word_t;

  typedef struct packed {
    logic [MOD_BITS-1:0] discriminant;
    logic                bad_exponents;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED,     // reduce operand by p, bit-serial restoring
    ST_GCD,     // binary-free gcd by subtraction
    ST_DIV,     // n/d and k/d, bit-serial
    ST_POWSET,  // load next power job
    ST_POW,     // square and multiply loop
    ST_MUL,     // shift-add modular multiply step
    ST_COMB,    // combine term step
    ST_DONE
  } state_t;

  // values reduced mod p, in order
  localparam logic [2:0] RED_A  = 3'd0;
  localparam logic [2:0] RED_B  = 3'd1;
  localparam logic [2:0] RED_N  = 3'd2;
  localparam logic [2:0] RED_NK = 3'd3;
  localparam logic [2:0] RED_K  = 3'd4;

  // power jobs, in the order they run
  localparam logic [2:0] JOB_T1    = 3'd0;  // b^(k-1)
  localparam logic [2:0] JOB_NPOW  = 3'd1;  // n^n1
  localparam logic [2:0] JOB_BPOW  = 3'd2;  // b^(n1-k1)
  localparam logic [2:0] JOB_NKPOW = 3'd3;  // (n-k)^(n1-k1)
  localparam logic [2:0] JOB_KPOW  = 3'd4;  // k^k1
  localparam logic [2:0] JOB_APOW  = 3'd5;  // a^n1
  localparam logic [2:0] JOB_DPOW  = 3'd6;  // (t2 - t3)^d
endpackage

FILE: src/trinomial_discriminant_mod_p.sv
// trinomial discriminant mod p, Swan's formula, one shared modular multiplier
// depends on tdm_pkg
//
// usage: write the modulus on cfg_ (one word, reset value 3); cfg_ready is high only
// while the sequencer is idle, and an input word waits while a cfg word is offered.
// send one word on in_ (degree, mid_exponent, coeff_a, coeff_b); one word comes back
// on out_ with the discriminant and the bad-exponent flag.
// one item at a time: in_ready is low from acceptance until the result is loaded
// into the output register, so the next word can be taken while a result waits.
// steps from acceptance: the five reductions, the gcd by repeated subtraction, the
// divisions n/d and k/d, then seven powers and four products; a power runs one
// multiply per exponent bit and per set bit, and a last step loads the output register.
// most of the time goes into the gcd when k is small; bad exponents or a zero modulus
// go straight to that last step.
// reset idles the sequencer, clears out_valid and sets the modulus to 3; when the
// receiver stalls the result waits in the output register, and a second item can be
// taken and computed behind it, then wait in the done state with in_ready low.
module trinomial_discriminant_mod_p (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  tdm_pkg::in_word_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tdm_pkg::out_word_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tdm_pkg::MOD_BITS-1:0] cfg_data
);
  localparam int MB = tdm_pkg::MOD_BITS;
  localparam int DB = tdm_pkg::DEG_BITS;
  localparam int CB = $clog2(MB + 1) + 1;

  tdm_pkg::state_t state_r, state_nxt;

  logic [MB-1:0] p_r;
  logic [DB-1:0] n_r, k_r, gx_r, gy_r, n1_r, k1_r;
  logic [MB-1:0] a_r, b_r;
  logic bad_r;
  logic [MB-1:0] res_r;
  logic          obad_r;
  logic          ovalid_r;

  // reduction unit: operand x mod p, one bit a cycle
  logic [MB-1:0] rsrc_r;   // shift source
  logic [MB-1:0] rrem_r;
  logic [CB-1:0] cnt_r;
  logic [2:0]    ridx_r;   // which value is being reduced
  logic [MB-1:0] nm_r, nkm_r, km_r;

  // division unit
  logic [DB-1:0] dq_r, drem_r;
  logic          dsel_r;   // 0: n/d, 1: k/d

  // power unit
  logic [2:0]    job_r;
  logic [MB-1:0] base_r, acc_r;
  logic [DB-1:0] exp_r;
  logic          mphase_r; // 0: acc*base, 1: base*base
  // multiplier
  logic [MB-1:0] mx_r, my_r;
  logic [MB-1:0] mr_r;
  logic [MB-1:0] t1_r, t2_r, t3_r, pw_r;
  logic          cmul_r;

  logic [MB:0] dbl, dbl_red, addv, add_red;
  logic [MB:0] rr_sh;
  logic [MB-1:0] mstep;

  always_comb begin
    dbl     = {mr_r, 1'b0};
    dbl_red = (dbl >= {1'b0, p_r}) ? dbl - {1'b0, p_r} : dbl;
    addv    = dbl_red + {1'b0, mx_r};
    add_red = (addv >= {1'b0, p_r}) ? addv - {1'b0, p_r} : addv;
    rr_sh   = {rrem_r, rsrc_r[MB-1]};
    mstep   = my_r[MB-1] ? add_red[MB-1:0] : dbl_red[MB-1:0];
  end

  // power job table: exponent and base
  logic [DB-1:0] job_exp;
  always_comb begin
    case (job_r)
      tdm_pkg::JOB_T1:    job_exp = k_r - DB'(1);
      tdm_pkg::JOB_NPOW:  job_exp = n1_r;
      tdm_pkg::JOB_BPOW:  job_exp = n1_r - k1_r;
      tdm_pkg::JOB_NKPOW: job_exp = n1_r - k1_r;
      tdm_pkg::JOB_KPOW:  job_exp = k1_r;
      tdm_pkg::JOB_APOW:  job_exp = n1_r;
      tdm_pkg::JOB_DPOW:  job_exp = gx_r;
      default:            job_exp = '0;
    endcase
  end

  logic [MB-1:0] job_base;
  always_comb begin
    case (job_r)
      tdm_pkg::JOB_T1:    job_base = b_r;
      tdm_pkg::JOB_NPOW:  job_base = nm_r;
      tdm_pkg::JOB_BPOW:  job_base = b_r;
      tdm_pkg::JOB_NKPOW: job_base = nkm_r;
      tdm_pkg::JOB_KPOW:  job_base = km_r;
      tdm_pkg::JOB_APOW:  job_base = a_r;
      default:            job_base = pw_r;
    endcase
  end

  // left operand of the product that follows a power
  logic [MB-1:0] mul_lhs;
  always_comb begin
    case (job_r)
      tdm_pkg::JOB_BPOW: mul_lhs = t2_r;
      tdm_pkg::JOB_KPOW: mul_lhs = t3_r;
      tdm_pkg::JOB_APOW: mul_lhs = t3_r;
      default:           mul_lhs = t1_r;
    endcase
  end

  logic comb_mul;
  assign comb_mul = !((job_r == tdm_pkg::JOB_T1) || (job_r == tdm_pkg::JOB_NPOW) ||
                      (job_r == tdm_pkg::JOB_NKPOW));

  // pw_r holds the full third term when the difference is formed
  logic [MB-1:0] sub_v, neg3, fin;
  always_comb begin
    neg3  = (pw_r == '0) ? '0 : p_r - pw_r;
    sub_v = (n1_r[0] ? ((t2_r >= neg3) ? t2_r - neg3 : t2_r + (p_r - neg3))
                     : ((t2_r >= pw_r) ? t2_r - pw_r : t2_r + (p_r - pw_r)));
    fin   = (n_r[1] && t1_r != '0) ? p_r - t1_r : t1_r;
  end

  assign in_ready  = (state_r == tdm_pkg::ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == tdm_pkg::ST_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = '{discriminant: res_r, bad_exponents: obad_r};

  logic in_fire, done_fire;
  assign in_fire   = in_valid && in_ready;
  assign done_fire = (state_r == tdm_pkg::ST_DONE) && (!ovalid_r || out_ready);

  logic bad_in;
  assign bad_in = (in_data.mid_exponent == '0) || (in_data.mid_exponent >= in_data.degree);

  // next state
  logic mul_last, red_last, div_last;
  assign mul_last = (cnt_r == CB'(MB - 1));
  assign red_last = (cnt_r == CB'(MB - 1));
  assign div_last = (cnt_r == CB'(DB - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tdm_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = (bad_in || p_r == '0) ? tdm_pkg::ST_DONE : tdm_pkg::ST_RED;
      end
      tdm_pkg::ST_RED: begin
        if (red_last && ridx_r == tdm_pkg::RED_K) state_nxt = tdm_pkg::ST_GCD;
      end
      tdm_pkg::ST_GCD: begin
        if (gx_r == gy_r) state_nxt = tdm_pkg::ST_DIV;
      end
      tdm_pkg::ST_DIV: begin
        if (div_last && dsel_r) state_nxt = tdm_pkg::ST_POWSET;
      end
      tdm_pkg::ST_POWSET: state_nxt = tdm_pkg::ST_POW;
      tdm_pkg::ST_POW: begin
        if (exp_r == '0) state_nxt = tdm_pkg::ST_COMB;
        else state_nxt = tdm_pkg::ST_MUL;
      end
      tdm_pkg::ST_MUL: begin
        if (mul_last) state_nxt = cmul_r ? tdm_pkg::ST_COMB : tdm_pkg::ST_POW;
      end
      tdm_pkg::ST_COMB: begin
        if (cmul_r) begin
          state_nxt = (job_r == tdm_pkg::JOB_DPOW) ? tdm_pkg::ST_DONE : tdm_pkg::ST_POWSET;
        end else begin
          state_nxt = comb_mul ? tdm_pkg::ST_MUL : tdm_pkg::ST_POWSET;
        end
      end
      tdm_pkg::ST_DONE: begin
        if (done_fire) state_nxt = tdm_pkg::ST_IDLE;
      end
      default: state_nxt = tdm_pkg::ST_IDLE;
    endcase
  end

  logic [MB-1:0] red_out;
  assign red_out = (rr_sh >= {1'b0, p_r}) ? MB'(rr_sh - {1'b0, p_r}) : rr_sh[MB-1:0];

  // next value to feed the reduction unit
  logic [MB-1:0] red_next;
  always_comb begin
    case (ridx_r)
      tdm_pkg::RED_A:  red_next = b_r;
      tdm_pkg::RED_B:  red_next = MB'(n_r);
      tdm_pkg::RED_N:  red_next = MB'(n_r - k_r);
      tdm_pkg::RED_NK: red_next = MB'(k_r);
      default:         red_next = '0;
    endcase
  end

  logic [DB:0] dsh;
  logic        dbit;
  assign dsh  = {drem_r, dq_r[DB-1]};
  assign dbit = (dsh >= {1'b0, gx_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tdm_pkg::ST_IDLE;
      p_r      <= MB'(3);
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_valid && cfg_ready) p_r <= cfg_data;
      ovalid_r <= done_fire || (ovalid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      tdm_pkg::ST_IDLE: begin
        if (in_fire) begin
          n_r    <= in_data.degree;
          k_r    <= in_data.mid_exponent;
          b_r    <= in_data.coeff_b;
          bad_r  <= bad_in;
          gx_r   <= in_data.degree;
          gy_r   <= in_data.mid_exponent;
          rsrc_r <= in_data.coeff_a;
          rrem_r <= '0;
          cnt_r  <= '0;
          ridx_r <= tdm_pkg::RED_A;
        end
      end
      tdm_pkg::ST_RED: begin
        if (red_last) begin
          case (ridx_r)
            tdm_pkg::RED_A:  a_r <= red_out;
            tdm_pkg::RED_B:  b_r <= red_out;
            tdm_pkg::RED_N:  nm_r <= red_out;
            tdm_pkg::RED_NK: nkm_r <= red_out;
            default:         km_r <= red_out;
          endcase
          cnt_r  <= '0;
          rrem_r <= '0;
          ridx_r <= ridx_r + 1'b1;
          rsrc_r <= red_next;
        end else begin
          rsrc_r <= {rsrc_r[MB-2:0], 1'b0};
          rrem_r <= red_out;
          cnt_r  <= cnt_r + 1'b1;
        end
        dq_r   <= n_r;
        drem_r <= '0;
        dsel_r <= 1'b0;
      end
      tdm_pkg::ST_GCD: begin
        if (gx_r > gy_r) gx_r <= gx_r - gy_r;
        else if (gy_r > gx_r) gy_r <= gy_r - gx_r;
        cnt_r <= '0;
      end
      tdm_pkg::ST_DIV: begin
        if (div_last) begin
          cnt_r  <= '0;
          drem_r <= '0;
          if (!dsel_r) begin
            n1_r <= {dq_r[DB-2:0], dbit};
            dq_r <= k_r;
          end else begin
            k1_r <= {dq_r[DB-2:0], dbit};
          end
          dsel_r <= 1'b1;
        end else begin
          cnt_r  <= cnt_r + 1'b1;
          drem_r <= dbit ? DB'(dsh - {1'b0, gx_r}) : dsh[DB-1:0];
          dq_r   <= {dq_r[DB-2:0], dbit};
        end
        job_r  <= tdm_pkg::JOB_T1;
        cmul_r <= 1'b0;
      end
      tdm_pkg::ST_POWSET: begin
        base_r   <= job_base;
        exp_r    <= job_exp;
        acc_r    <= (p_r == MB'(1)) ? '0 : MB'(1);
        mphase_r <= 1'b0;
      end
      tdm_pkg::ST_POW: begin
        cnt_r <= '0;
        mr_r  <= '0;
        if (exp_r != '0) begin
          if (!mphase_r && exp_r[0]) begin
            mx_r <= acc_r; my_r <= base_r;
          end else begin
            mphase_r <= 1'b1;
            mx_r <= base_r; my_r <= base_r;
          end
        end else begin
          pw_r <= acc_r;
        end
      end
      tdm_pkg::ST_MUL: begin
        if (mul_last) begin
          cnt_r <= '0;
          if (cmul_r) begin
            pw_r <= mstep;
          end else if (!mphase_r && exp_r[0]) begin
            acc_r    <= mstep;
            mphase_r <= 1'b1;
          end else begin
            base_r   <= mstep;
            exp_r    <= exp_r >> 1;
            mphase_r <= 1'b0;
          end
        end else begin
          cnt_r <= cnt_r + 1'b1;
          my_r  <= {my_r[MB-2:0], 1'b0};
          mr_r  <= mstep;
        end
      end
      tdm_pkg::ST_COMB: begin
        // pw_r holds the newest power or product
        mr_r  <= '0;
        cnt_r <= '0;
        if (cmul_r) begin
          cmul_r <= 1'b0;
          case (job_r)
            tdm_pkg::JOB_BPOW: t2_r <= pw_r;
            tdm_pkg::JOB_KPOW: t3_r <= pw_r;
            tdm_pkg::JOB_APOW: pw_r <= sub_v;
            default:           t1_r <= pw_r;
          endcase
          job_r <= job_r + 1'b1;
        end else begin
          case (job_r)
            tdm_pkg::JOB_T1: begin
              t1_r  <= pw_r;
              job_r <= tdm_pkg::JOB_NPOW;
            end
            tdm_pkg::JOB_NPOW: begin
              t2_r  <= pw_r;
              job_r <= tdm_pkg::JOB_BPOW;
            end
            tdm_pkg::JOB_NKPOW: begin
              t3_r  <= pw_r;
              job_r <= tdm_pkg::JOB_KPOW;
            end
            default: begin
              cmul_r <= 1'b1;
              mx_r   <= mul_lhs;
              my_r   <= pw_r;
            end
          endcase
        end
      end
      tdm_pkg::ST_DONE: begin
        if (done_fire) begin
          res_r  <= (bad_r || p_r == '0) ? '0 : fin;
          obad_r <= bad_r;
        end
      end
      default: ;
    endcase
  end
endmodule

FILE: bench/tb.sv
// testbench for trinomial_discriminant_mod_p: table of directed words, then random words
// checked against an in-bench Swan's formula predictor; depends on tdm_pkg and the rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 20000000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  tdm_pkg::in_word_t in_data;
  tdm_pkg::out_word_t out_data;
  logic [tdm_pkg::MOD_BITS-1:0] cfg_data;

  trinomial_discriminant_mod_p dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  logic [tdm_pkg::MOD_BITS-1:0] modulus_q;
  tdm_pkg::out_word_t disc_q[$];
  int errors = 0;
  int cycles = 0;
  int words_in = 0, words_out = 0;
  int send_idle = 0, recv_idle = 0;
  bit hold_recv = 0;

  function automatic logic [63:0] mmul(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [127:0] t;
    t = x * y;
    return t % m;
  endfunction

  function automatic logic [63:0] mpow(logic [63:0] x, logic [63:0] e, logic [63:0] m);
    logic [63:0] r;
    r = 1 % m;
    while (e != 0) begin
      if (e[0]) r = mmul(r, x, m);
      x = mmul(x, x, m);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic [63:0] mneg(logic [63:0] x, logic [63:0] m);
    return (x == 0) ? 0 : m - x;
  endfunction

  function automatic tdm_pkg::out_word_t swan_disc(tdm_pkg::in_word_t w,
                                                   logic [tdm_pkg::MOD_BITS-1:0] pm);
    tdm_pkg::out_word_t r;
    logic [63:0] n, k, a, b, p, d, x, y, n1, k1, t1, t2, t3;
    n = w.degree; k = w.mid_exponent; p = pm;
    r.bad_exponents = (k == 0) || (k >= n);
    r.discriminant = '0;
    if (r.bad_exponents || p == 0) return r;
    a = w.coeff_a % p; b = w.coeff_b % p;
    x = n; y = k;
    while (y != 0) begin
      d = x % y; x = y; y = d;
    end
    d = x; n1 = n / d; k1 = k / d;
    t1 = mpow(b, k - 1, p);
    t2 = mmul(mpow(n % p, n1, p), mpow(b, n1 - k1, p), p);
    t3 = mmul(mpow((n - k) % p, n1 - k1, p), mpow(k % p, k1, p), p);
    t3 = mmul(t3, mpow(a, n1, p), p);
    if (n1[0]) t3 = mneg(t3, p);
    t2 = mpow((t2 >= t3) ? t2 - t3 : t2 + (p - t3), d, p);
    t1 = mmul(t1, t2, p);
    if (n[1]) t1 = mneg(t1, p);
    r.discriminant = t1[tdm_pkg::MOD_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_recv && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      words_out <= words_out + 1;
      if (disc_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        tdm_pkg::out_word_t e;
        e = disc_q.pop_front();
        if (out_data.discriminant !== e.discriminant) begin
          $error("discriminant expected %0d got %0d", e.discriminant, out_data.discriminant);
          errors++;
        end
        if (out_data.bad_exponents !== e.bad_exponents) begin
          $error("bad_exponents expected %0d got %0d", e.bad_exponents,
                 out_data.bad_exponents);
          errors++;
        end
      end
    end
  end

  // valid stays high after acceptance unless the sender idles or drains
  task automatic send_word(tdm_pkg::in_word_t w, bit typed = 0,
                           tdm_pkg::out_word_t typed_res = '0);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    disc_q.push_back(typed ? typed_res : swan_disc(w, modulus_q));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_in++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (disc_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_modulus(logic [tdm_pkg::MOD_BITS-1:0] m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    modulus_q = m;
  endtask

  function automatic tdm_pkg::in_word_t rand_word(bit large_exp);
    tdm_pkg::in_word_t w;
    w.degree = large_exp ? 16'($urandom) : 16'($urandom_range(40, 2));
    w.mid_exponent = ($urandom_range(9) == 0) ? 16'($urandom)
                   : 16'($urandom_range(w.degree - 1, 1));
    w.coeff_a = ($urandom_range(3) == 0) ? 32'($urandom_range(5)) : $urandom;
    w.coeff_b = ($urandom_range(3) == 0) ? 32'($urandom_range(5)) : $urandom;
    return w;
  endfunction

  typedef struct {
    tdm_pkg::in_word_t w;
    bit typed;
    tdm_pkg::out_word_t res;
  } dir_row_t;

  dir_row_t dir_tab[$];

  initial begin
    logic [tdm_pkg::MOD_BITS-1:0] mods[] = '{32'd3, 32'hFFFFFFFB, 32'd0, 32'd1, 32'd65521,
                                            32'hFFFFFFFF};
    int phase;
    rst_n = 0; in_valid = 0; in_data = '0; cfg_valid = 0; cfg_data = '0;
    modulus_q = 3;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // k = 0, k = n, k > n: flagged with zero discriminant
    dir_tab.push_back('{'{16'd5, 16'd0, 32'd1, 32'd1}, 1, '{32'd0, 1'b1}});
    dir_tab.push_back('{'{16'd7, 16'd7, 32'd2, 32'd2}, 1, '{32'd0, 1'b1}});
    dir_tab.push_back('{'{16'hFFFF, 16'hFFFF, '1, '1}, 1, '{32'd0, 1'b1}});
    dir_tab.push_back('{'{16'd2, 16'd3, 32'd0, 32'd0}, 1, '{32'd0, 1'b1}});
    dir_tab.push_back('{'{16'd0, 16'd0, 32'd0, 32'd0}, 1, '{32'd0, 1'b1}});
    // b = 0 with k > 1 gives zero; then directed words checked by the predictor
    dir_tab.push_back('{'{16'd5, 16'd2, 32'd1, 32'd0}, 1, '{32'd0, 1'b0}});
    dir_tab.push_back('{'{16'd2, 16'd1, 32'd0, 32'd0}, 0, '0});
    dir_tab.push_back('{'{16'd2, 16'd1, '1, '1}, 0, '0});
    dir_tab.push_back('{'{16'd3, 16'd1, 32'd1, 32'd1}, 0, '0});
    dir_tab.push_back('{'{16'd4, 16'd2, 32'd3, 32'd5}, 0, '0});
    dir_tab.push_back('{'{16'd6, 16'd4, 32'd7, 32'd2}, 0, '0});
    dir_tab.push_back('{'{16'hFFFF, 16'hFFFE, '1, '1}, 0, '0});
    dir_tab.push_back('{'{16'hFFFF, 16'd1, 32'hAAAAAAAA, 32'h55555555}, 0, '0});
    dir_tab.push_back('{'{16'h8000, 16'h4000, 32'h55555555, 32'hAAAAAAAA}, 0, '0});
    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res);
    write_modulus(32'hFFFFFFFB);
    foreach (dir_tab[i]) send_word(dir_tab[i].w);

    for (phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 15 : (phase == 1) ? 48 : 0;
      recv_idle = (phase == 0) ? 48 : (phase == 1) ? 15 : 0;
      // every fixed modulus, then one random odd one
      for (int m = 0; m <= mods.size(); m++) begin
        write_modulus((m < mods.size()) ? mods[m] : ($urandom | 32'd1));
        for (int j = 0; j < 13; j++) send_word(rand_word($urandom_range(15) == 0));
      end
      // long hold-off on the receiver while words keep coming
      fork
        begin
          hold_recv = 1;
          repeat (20000) @(posedge clk);
          hold_recv = 0;
        end
        for (int j = 0; j < 3; j++) send_word(rand_word(0));
      join
      drain();
    end
    write_modulus(32'd3);
    for (int j = 0; j < 5; j++) send_word(rand_word(0));
    drain();
    $display("%0d words sent, %0d results checked over several moduli incl. 0, 1, max",
             words_in, words_out);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
